FILE: sv/uart_dual_ring_buffer_unit_defines.svh
// ----------------------------------------------------------------------------
// uart_dual_ring_buffer_unit_defines.svh
// Assertion macros shared by the serial port ring buffer RTL.
// ----------------------------------------------------------------------------
`ifndef UART_DUAL_RING_BUFFER_UNIT_DEFINES_SVH
`define UART_DUAL_RING_BUFFER_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define UDRB_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define UDRB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/udrb_pkg.sv
// ----------------------------------------------------------------------------
// udrb_pkg
// Types and constants of the serial port dual ring buffer.
// ----------------------------------------------------------------------------
package udrb_pkg;

  localparam int BUF_SIZE_DEF = 64;
  localparam int DATA_W       = 9;
  localparam int ACT_W        = 3;
  localparam int CNT_W        = 12;
  localparam int DBITS_W      = 4;
  localparam int CFG_AW       = 4;
  localparam int CFG_DW       = 32;
  localparam int IN_TDATA_W   = 16;
  localparam int OUT_TDATA_W  = 40;

  localparam logic [DBITS_W-1:0] DBITS_RST = 4'd8;
  localparam logic [DBITS_W-1:0] DBITS_MIN = 4'd7;
  localparam logic [DBITS_W-1:0] DBITS_MAX = 4'd9;

  typedef enum logic [1:0] {
    REG_DATA_BITS   = 2'd0,
    REG_HALF_DUPLEX = 2'd1,
    REG_NO_ECHO     = 2'd2,
    REG_UNUSED      = 2'd3
  } reg_idx_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_RX_CHAR    = 3'd0,
    ACT_HOST_WRITE = 3'd1,
    ACT_READ       = 3'd2,
    ACT_PEEK       = 3'd3,
    ACT_TXE_EVENT  = 3'd4,
    ACT_TC_EVENT   = 3'd5,
    ACT_CLEAR      = 3'd6,
    ACT_NOP        = 3'd7
  } action_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  // character mask for the configured data-bit count (clamped to 7..9)
  function automatic logic [DATA_W-1:0] word_mask(input logic [DBITS_W-1:0] nbits);
    logic [DATA_W-1:0] m;
    if (nbits <= DBITS_MIN) begin
      m = 9'h07F;
    end else if (nbits >= DBITS_MAX) begin
      m = 9'h1FF;
    end else begin
      m = 9'h0FF;
    end
    return m;
  endfunction

endpackage

FILE: sv/uart_dual_ring_buffer_unit.sv
// ----------------------------------------------------------------------------
// uart_dual_ring_buffer_unit
// Receive and transmit ring buffers of a serial port with APB setup regs.
// ----------------------------------------------------------------------------
// A transaction is accepted in IDLE and runs in EXEC; its result is
//   loaded into the result register in EXEC once that register is free.
// No new transaction is accepted until the last result is loaded. The ring
//   memories have one registered read port, read at accept, written in EXEC.
// Reset (rst_n, synchronous, low): pointers, arms, enables and setup regs go
//   to their defaults at once; memory contents are not cleared (no sweep).
// ----------------------------------------------------------------------------
`include "uart_dual_ring_buffer_unit_defines.svh"

module uart_dual_ring_buffer_unit #(
  parameter int BUF_SIZE = udrb_pkg::BUF_SIZE_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [udrb_pkg::IN_TDATA_W-1:0]    in_tdata,   // [8:0] data_in, rest zero
  input  logic [udrb_pkg::ACT_W-1:0]         in_tuser,   // [2:0] action
  // result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [8:0] data_out, [9] data_valid, [10] accepted, [11] send_valid,
  // [23:12] rx_count, [35:24] tx_space, [36] tx_enable, [37] rx_enable,
  // [38] txe_irq_enable, [39] tc_irq_enable
  output logic [udrb_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // APB setup port
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [udrb_pkg::CFG_AW-1:0]        cfg_paddr,
  input  logic [udrb_pkg::CFG_DW-1:0]        cfg_pwdata,
  output logic [udrb_pkg::CFG_DW-1:0]        cfg_prdata,
  output logic                               cfg_pready
);
  import udrb_pkg::*;

  localparam int PTR_W = $clog2(BUF_SIZE);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(BUF_SIZE - 1);
  localparam logic [PTR_W-1:0] SIZE_MOD  = PTR_W'(BUF_SIZE);
  localparam logic [CNT_W-1:0] SPACE_MAX = CNT_W'(BUF_SIZE - 1);

  typedef logic [PTR_W-1:0] ptr_t;

  // wrap-around increment, works for any ring size
  function automatic ptr_t ptr_inc(input ptr_t p);
    return (p == LAST_SLOT) ? '0 : p + ptr_t'(1);
  endfunction

  // occupied slots; modulo arithmetic on PTR_W bits
  function automatic ptr_t ptr_used(input ptr_t head, input ptr_t tail);
    return (head >= tail) ? head - tail : head - tail + SIZE_MOD;
  endfunction

  // --------------------------------------------------------------------------
  // Setup registers
  // --------------------------------------------------------------------------
  logic [DBITS_W-1:0] data_bits_r;
  logic               half_duplex_r;
  logic               no_echo_r;
  logic               cfg_wr;
  reg_idx_t           cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_bits_r   <= DBITS_RST;
      half_duplex_r <= 1'b0;
      no_echo_r     <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_DATA_BITS:   data_bits_r   <= cfg_pwdata[DBITS_W-1:0];
        REG_HALF_DUPLEX: half_duplex_r <= cfg_pwdata[0];
        REG_NO_ECHO:     no_echo_r     <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    case (cfg_idx)
      REG_DATA_BITS:   cfg_prdata = CFG_DW'(data_bits_r);
      REG_HALF_DUPLEX: cfg_prdata = CFG_DW'(half_duplex_r);
      REG_NO_ECHO:     cfg_prdata = CFG_DW'(no_echo_r);
      default:         cfg_prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: IDLE takes a transaction and launches the ring reads,
  // EXEC has the read data, updates state and loads the result register.
  // --------------------------------------------------------------------------
  state_t  state_r, state_nxt;
  logic    in_acc;
  logic    res_load;
  action_t act_r;
  logic [DATA_W-1:0] din_r;

  assign in_acc = in_tvalid & in_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_EXEC;
      ST_EXEC: if (res_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // result register is free or being drained this cycle
  always_comb begin
    in_tready = (state_r == ST_IDLE);
    res_load  = (state_r == ST_EXEC) && (!out_tvalid || out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r <= action_t'(in_tuser);
      din_r <= in_tdata[DATA_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Pointers, arms and enables
  // --------------------------------------------------------------------------
  ptr_t rx_head_r, rx_tail_r, tx_head_r, tx_tail_r;
  ptr_t rx_head_nxt, rx_tail_nxt, tx_head_nxt, tx_tail_nxt;
  logic txe_armed_r, tc_armed_r, tx_on_r, rx_on_r;
  logic txe_armed_nxt, tc_armed_nxt, tx_on_nxt, rx_on_nxt;

  // ring memories: one write and one registered read per cycle each
  logic [DATA_W-1:0] rx_mem [BUF_SIZE];
  logic [DATA_W-1:0] tx_mem [BUF_SIZE];
  logic [DATA_W-1:0] rx_rdata_r, tx_rdata_r;
  logic              rx_we, tx_we;
  logic [DATA_W-1:0] wdata;

  // tails do not move between accept and exec, so the read is current
  always_ff @(posedge clk) begin
    if (rx_we && res_load) rx_mem[rx_head_r] <= wdata;
    if (in_acc) rx_rdata_r <= rx_mem[rx_tail_r];
  end

  always_ff @(posedge clk) begin
    if (tx_we && res_load) tx_mem[tx_head_r] <= wdata;
    if (in_acc) tx_rdata_r <= tx_mem[tx_tail_r];
  end

  // --------------------------------------------------------------------------
  // Exec step
  // --------------------------------------------------------------------------
  logic              quiet;
  logic              rx_full, tx_full, rx_empty, tx_empty;
  logic [DATA_W-1:0] dout;
  logic              dvalid, acc, svalid;

  assign quiet    = half_duplex_r & no_echo_r;
  assign rx_full  = (ptr_inc(rx_head_r) == rx_tail_r);
  assign tx_full  = (ptr_inc(tx_head_r) == tx_tail_r);
  assign rx_empty = (rx_head_r == rx_tail_r);
  assign tx_empty = (tx_head_r == tx_tail_r);
  assign wdata    = din_r & word_mask(data_bits_r);

  always_comb begin
    rx_head_nxt   = rx_head_r;
    rx_tail_nxt   = rx_tail_r;
    tx_head_nxt   = tx_head_r;
    tx_tail_nxt   = tx_tail_r;
    txe_armed_nxt = txe_armed_r;
    tc_armed_nxt  = tc_armed_r;
    tx_on_nxt     = tx_on_r;
    rx_on_nxt     = rx_on_r;
    rx_we         = 1'b0;
    tx_we         = 1'b0;
    dout          = '0;
    dvalid        = 1'b0;
    acc           = 1'b0;
    svalid        = 1'b0;
    case (act_r)
      ACT_RX_CHAR: begin
        if (!rx_full) begin
          rx_we       = 1'b1;
          rx_head_nxt = ptr_inc(rx_head_r);
          acc         = 1'b1;
        end
      end
      ACT_HOST_WRITE: begin
        if (!tx_full) begin
          tx_we       = 1'b1;
          tx_head_nxt = ptr_inc(tx_head_r);
          acc         = 1'b1;
        end
        txe_armed_nxt = 1'b1;
      end
      ACT_READ, ACT_PEEK: begin
        if (!rx_empty) begin
          dout   = rx_rdata_r;
          dvalid = 1'b1;
          if (act_r == ACT_READ) rx_tail_nxt = ptr_inc(rx_tail_r);
        end
      end
      ACT_TXE_EVENT: begin
        if (txe_armed_r) begin
          if (tx_empty) begin
            txe_armed_nxt = 1'b0;
            if (quiet) tc_armed_nxt = 1'b1;
          end else begin
            if (quiet) begin
              tx_on_nxt = 1'b1;
              rx_on_nxt = 1'b0;
            end
            dout        = tx_rdata_r;
            svalid      = 1'b1;
            tx_tail_nxt = ptr_inc(tx_tail_r);
          end
        end
      end
      ACT_TC_EVENT: begin
        if (tc_armed_r && quiet) begin
          tc_armed_nxt = 1'b0;
          tx_on_nxt    = 1'b0;
          rx_on_nxt    = 1'b1;
        end
      end
      ACT_CLEAR: begin
        rx_head_nxt = rx_tail_r;
        tx_head_nxt = tx_tail_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_head_r   <= '0;
      rx_tail_r   <= '0;
      tx_head_r   <= '0;
      tx_tail_r   <= '0;
      txe_armed_r <= 1'b1;
      tc_armed_r  <= 1'b0;
      tx_on_r     <= 1'b1;
      rx_on_r     <= 1'b1;
    end else if (res_load) begin
      rx_head_r   <= rx_head_nxt;
      rx_tail_r   <= rx_tail_nxt;
      tx_head_r   <= tx_head_nxt;
      tx_tail_r   <= tx_tail_nxt;
      txe_armed_r <= txe_armed_nxt;
      tc_armed_r  <= tc_armed_nxt;
      tx_on_r     <= tx_on_nxt;
      rx_on_r     <= rx_on_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  logic              out_tvalid_r;
  logic [DATA_W-1:0] res_dout_r;
  logic              res_dvalid_r, res_acc_r, res_svalid_r;
  logic [CNT_W-1:0]  res_rx_count_r, res_tx_space_r;
  logic              res_tx_en_r, res_rx_en_r, res_txe_r, res_tc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (res_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_dout_r     <= dout;
      res_dvalid_r   <= dvalid;
      res_acc_r      <= acc;
      res_svalid_r   <= svalid;
      res_rx_count_r <= CNT_W'(ptr_used(rx_head_nxt, rx_tail_nxt));
      res_tx_space_r <= SPACE_MAX - CNT_W'(ptr_used(tx_head_nxt, tx_tail_nxt));
      res_tx_en_r    <= tx_on_nxt;
      res_rx_en_r    <= rx_on_nxt;
      res_txe_r      <= txe_armed_nxt;
      res_tc_r       <= tc_armed_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {res_tc_r, res_txe_r, res_rx_en_r, res_tx_en_r,
                       res_tx_space_r, res_rx_count_r,
                       res_svalid_r, res_acc_r, res_dvalid_r, res_dout_r};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `UDRB_ASSERT_NEXT(a_acc_to_exec, clk, rst_n, in_acc, state_r == ST_EXEC,
                    "accept did not start exec")
  `UDRB_ASSERT_NEXT(a_load_shows, clk, rst_n, res_load, out_tvalid_r,
                    "loaded result not presented")
  `UDRB_ASSERT_NEXT(a_exec_holds, clk, rst_n, (state_r == ST_EXEC) && !res_load,
                    (state_r == ST_EXEC) && $stable(act_r) && $stable(din_r),
                    "stalled exec lost its transaction")
  `UDRB_ASSERT_NOW(a_acc_kind, clk, rst_n, res_load && acc,
                   (act_r == ACT_RX_CHAR) || (act_r == ACT_HOST_WRITE),
                   "store flag on a non-store action")
  `UDRB_ASSERT_NOW(a_one_source, clk, rst_n, res_load, !(dvalid && svalid),
                   "read and send in one result")

endmodule
